FILE: design/csrspmv_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// csrspmv_pkg
// Shared types and constants of the compressed-row sparse matrix-vector
// multiply block.
// ============================================================================
package csrspmv_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned ROW_W  = 16;

  // Depth of the work queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } opcode_e;

  // One unit of work for the multiply-accumulate part.
  typedef struct packed {
    logic                    empty_row;
    logic                    row_end;
    logic signed [VAL_W-1:0] mat_val;
    logic signed [VAL_W-1:0] vec_val;
  } work_t;

endpackage

FILE: design/csr_sparse_matrix_vector_multiply.sv
`timescale 1ns / 1ps
// ============================================================================
// csr_sparse_matrix_vector_multiply
// Compressed-row sparse matrix times dense vector, Q8.8 inputs, Q32.16 sums.
// ============================================================================
// Usage:
//   Input words arrive on in_valid_i / in_ready_o. An opcode of load writes
//   value_i into the vector store at index_i. A nonzero word multiplies
//   value_i by the stored entry at column index_i and adds the product to a
//   saturating 48-bit accumulator; with row_end_i set it also closes the row.
//   An empty-row word closes the row without adding anything.
//   Each closed row gives one output word on out_valid_o / out_ready_i with
//   the row index, the sum, a last-row mark and a saturation flag.
//   cfg_we_i / cfg_wdata_i set the row count; write it only while idle.
// Timing:
//   One input word per cycle is accepted as long as results are taken. A row
//   sum is presented once the word that closes the row has passed the store
//   read register, the work queue and the multiplier register, and the
//   accumulate step has written the sum into the output register.
// Reset and stalls:
//   Reset clears the accumulator, the row counter and all valid flags and sets
//   the row count to one; the vector store keeps whatever it held and must be
//   loaded before use. When the receiver stalls, the finished sum waits in the
//   output register; later words flow on until the next row-closing word
//   reaches the multiplier register, then the queue fills and in_ready_o drops.
// ============================================================================
module csr_sparse_matrix_vector_multiply #(
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [csrspmv_pkg::ROW_W-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           opcode_i,
  input  logic [csrspmv_pkg::IDX_W-1:0]        index_i,
  input  logic signed [csrspmv_pkg::VAL_W-1:0] value_i,
  input  logic                                 row_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [csrspmv_pkg::ROW_W-1:0]        row_index_o,
  output logic signed [csrspmv_pkg::ACC_W-1:0] row_sum_o,
  output logic                                 last_row_o,
  output logic                                 saturated_o
);
  import csrspmv_pkg::*;

  logic [ROW_W-1:0] row_count_q;

  logic  fq_valid;
  logic  fq_ready;
  work_t fq_data;
  logic  qb_valid;
  logic  qb_ready;
  work_t qb_data;

  // Row count register; the back part compares against it when a row closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_W'(1);
    end else if (cfg_we_i) begin
      row_count_q <= cfg_wdata_i;
    end
  end

  // The front part owns the vector store, so a load followed at once by a
  // nonzero on the same column reads the new entry.
  csrspmv_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .row_end_i  (row_end_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  csrspmv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_data),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_data)
  );

  csrspmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_count_i (row_count_q),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_data_i    (qb_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .row_sum_o   (row_sum_o),
    .last_row_o  (last_row_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: design/csrspmv_front.sv
`timescale 1ns / 1ps
// ============================================================================
// csrspmv_front
// Accepts input words, keeps the vector store and turns matrix words into
// queue entries carrying both operands.
// ============================================================================
module csrspmv_front #(
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           opcode_i,
  input  logic [csrspmv_pkg::IDX_W-1:0]        index_i,
  input  logic signed [csrspmv_pkg::VAL_W-1:0] value_i,
  input  logic                                 row_end_i,
  output logic                                 q_valid_o,
  input  logic                                 q_ready_i,
  output csrspmv_pkg::work_t                   q_data_o
);
  import csrspmv_pkg::*;

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [VAL_W-1:0]    mem [MAX_COLS];
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       addr;
  logic                in_range;
  logic                accept;
  logic                is_load;
  logic                is_work;

  logic                    st_valid_q, st_valid_d;
  logic                    st_empty_q;
  logic                    st_end_q;
  logic                    st_inrange_q;
  logic signed [VAL_W-1:0] st_val_q;
  logic [VAL_W-1:0]        rd_data_q;

  assign idx_ext  = (AW+IDX_W)'(index_i);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = (32'(index_i) < 32'(MAX_COLS));

  assign in_ready_o = !st_valid_q || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_load = 1'b0;
    is_work = 1'b0;
    unique case (opcode_e'(opcode_i))
      OP_LOAD:    is_load = 1'b1;
      OP_NONZERO: is_work = 1'b1;
      OP_EMPTY:   is_work = 1'b1;
      default:    is_work = 1'b0;
    endcase
  end

  // The store is written and read only on accepted words, so the read data
  // register holds while the staged entry waits for room in the queue.
  always_ff @(posedge clk_i) begin
    if (accept && is_load && in_range) begin
      mem[addr] <= value_i;
    end
    if (accept) begin
      rd_data_q <= mem[addr];
    end
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = is_work;
    end else if (q_ready_i) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_empty_q   <= (opcode_e'(opcode_i) == OP_EMPTY);
      st_end_q     <= row_end_i;
      st_inrange_q <= in_range;
      st_val_q     <= value_i;
    end
  end

  assign q_valid_o          = st_valid_q;
  assign q_data_o.empty_row = st_empty_q;
  assign q_data_o.row_end   = st_end_q;
  assign q_data_o.mat_val   = st_val_q;
  assign q_data_o.vec_val   = st_inrange_q ? $signed(rd_data_q) : '0;

endmodule

FILE: design/csrspmv_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// csrspmv_queue
// Short first-in first-out queue of work entries between front and back.
// ============================================================================
module csrspmv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  csrspmv_pkg::work_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output csrspmv_pkg::work_t rd_data_o
);
  import csrspmv_pkg::*;

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  work_t          buf_q [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push;
  logic           pop;

  assign wr_ready_o = (cnt_q != CW'(Q_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: design/csrspmv_back.sv
`timescale 1ns / 1ps
// ============================================================================
// csrspmv_back
// Multiplies, accumulates with saturation and holds finished row sums in an
// output register.
// ============================================================================
module csrspmv_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [csrspmv_pkg::ROW_W-1:0]        row_count_i,
  input  logic                                 q_valid_i,
  output logic                                 q_ready_o,
  input  csrspmv_pkg::work_t                   q_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [csrspmv_pkg::ROW_W-1:0]        row_index_o,
  output logic signed [csrspmv_pkg::ACC_W-1:0] row_sum_o,
  output logic                                 last_row_o,
  output logic                                 saturated_o
);
  import csrspmv_pkg::*;

  // Product stage.
  logic                     b_valid_q, b_valid_d;
  logic                     b_empty_q;
  logic                     b_end_q;
  logic signed [PROD_W-1:0] b_prod_q;

  // Accumulator state.
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic [ROW_W-1:0]        row_cnt_q, row_cnt_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [ROW_W-1:0]        out_row_q;
  logic signed [ACC_W-1:0] out_sum_q;
  logic                    out_last_q;
  logic                    out_sat_q;

  logic                    out_free;
  logic                    b_emits;
  logic                    b_fire;
  logic                    b_load;
  logic signed [ACC_W:0]   sum_wide;
  logic                    sum_ovf;
  logic signed [ACC_W-1:0] added;
  logic signed [ACC_W-1:0] new_acc;
  logic                    new_ovf;
  logic [ROW_W-1:0]        last_idx;
  logic                    is_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign b_emits   = b_empty_q || b_end_q;
  assign b_fire    = b_valid_q && (!b_emits || out_free);
  assign b_load    = !b_valid_q || b_fire;
  assign q_ready_o = b_load;

  always_comb begin
    b_valid_d = b_valid_q;
    if (b_load) begin
      b_valid_d = q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load && q_valid_i) begin
      b_empty_q <= q_data_i.empty_row;
      b_end_q   <= q_data_i.row_end;
      b_prod_q  <= q_data_i.mat_val * q_data_i.vec_val;
    end
  end

  // Saturating add of the registered product.
  assign sum_wide = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(b_prod_q);
  assign sum_ovf  = sum_wide[ACC_W] ^ sum_wide[ACC_W-1];
  assign added    = sum_ovf ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX)
                            : sum_wide[ACC_W-1:0];
  assign new_acc  = b_empty_q ? acc_q : added;
  assign new_ovf  = ovf_q || (!b_empty_q && sum_ovf);

  assign last_idx = row_count_i - ROW_W'(1);
  assign is_last  = (row_cnt_q == last_idx);

  always_comb begin
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    row_cnt_d   = row_cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (b_fire) begin
      if (b_emits) begin
        acc_d       = '0;
        ovf_d       = 1'b0;
        row_cnt_d   = is_last ? '0 : row_cnt_q + ROW_W'(1);
        out_valid_d = 1'b1;
      end else begin
        acc_d = new_acc;
        ovf_d = new_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && b_emits) begin
      out_row_q  <= row_cnt_q;
      out_sum_q  <= new_acc;
      out_last_q <= is_last;
      out_sat_q  <= new_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign row_sum_o   = out_sum_q;
  assign last_row_o  = out_last_q;
  assign saturated_o = out_sat_q;

  // A row is closed only when the output register can take its sum.
  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_emits) |-> out_free)
    else $error("row closed while output register is occupied");

  // Closing a row leaves a clean accumulator for the next one.
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_emits) |=> (acc_q == '0 && !ovf_q))
    else $error("accumulator not cleared after row close");

  // The row counter steps exactly once per closed row.
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_emits) |=>
      (row_cnt_q == ($past(is_last) ? '0 : $past(row_cnt_q) + ROW_W'(1))))
    else $error("row counter did not advance correctly");

  // Without a closed row the counter stays put.
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(b_fire && b_emits) |=> $stable(row_cnt_q))
    else $error("row counter moved without a closed row");

endmodule
